// File: design/pvsd_pkg.sv
// Shared types, constants and helper functions for the packed varint stream decoder.
package pvsd_pkg;

	localparam int VALUE_W  = 64;
	localparam int INDEX_W  = 16;
	localparam int GROUP_W  = 7;
	localparam int CNT_W    = 4;
	localparam int TYPE_W   = 3;
	localparam int CONT_BIT = 7;

	localparam logic [CNT_W-1:0]   MAX_GROUPS = CNT_W'(10);
	localparam logic [INDEX_W-1:0] INDEX_MAX  = '1;

	// value_type codes; the unused codes decode as varint64
	localparam logic [TYPE_W-1:0] VT_BOOL     = 3'd0;
	localparam logic [TYPE_W-1:0] VT_VARINT32 = 3'd1;
	localparam logic [TYPE_W-1:0] VT_VARINT64 = 3'd2;
	localparam logic [TYPE_W-1:0] VT_ZIGZAG32 = 3'd3;
	localparam logic [TYPE_W-1:0] VT_ZIGZAG64 = 3'd4;
	localparam logic [TYPE_W-1:0] VT_RESET    = VT_VARINT64;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               malformed;
		logic               is_last;
		logic [INDEX_W-1:0] element_index;
	} res_t;

	// one result candidate from the decode stage
	typedef struct packed {
		logic valid;
		res_t res;
	} res_req_t;

	// place a 7-bit group at its little-endian position; bits past 64 drop
	function automatic logic [VALUE_W-1:0] place_group(input logic [CNT_W-1:0] idx,
		input logic [GROUP_W-1:0] grp);
		logic [VALUE_W-1:0] ext;
		logic [VALUE_W-1:0] r;
		ext = {{(VALUE_W-GROUP_W){1'b0}}, grp};
		case (idx)
			4'd0:    r = ext;
			4'd1:    r = ext << 7;
			4'd2:    r = ext << 14;
			4'd3:    r = ext << 21;
			4'd4:    r = ext << 28;
			4'd5:    r = ext << 35;
			4'd6:    r = ext << 42;
			4'd7:    r = ext << 49;
			4'd8:    r = ext << 56;
			4'd9:    r = ext << 63;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [VALUE_W-1:0] convert(input logic [TYPE_W-1:0] vt,
		input logic [VALUE_W-1:0] raw);
		logic [31:0]        n32;
		logic [VALUE_W-1:0] r;
		n32 = raw[31:0];
		case (vt)
			VT_BOOL:     r = {{(VALUE_W-1){1'b0}}, |raw};
			VT_VARINT32: r = {32'b0, n32};
			VT_ZIGZAG32: r = {32'b0, (n32 >> 1) ^ {32{n32[0]}}};
			VT_ZIGZAG64: r = (raw >> 1) ^ {VALUE_W{raw[0]}};
			default:     r = raw;
		endcase
		return r;
	endfunction

endpackage

// File: design/packed_varint_stream_decoder.sv
// Top level of the packed varint stream decoder: input register, decode stage, result register.
//
// Channel   Dir  Handshake               Payload
// in        in   in_valid / in_ready     data_byte[7:0], region_end
// out       out  out_valid / out_ready   value[63:0], malformed, is_last, element_index[15:0]
// cfg       in   cfg_valid / cfg_ready   cfg_data[2:0] (value_type, reset varint64)
//
// One byte per cycle sustained while the out channel takes its results; the input register loads at
// the byte's transaction and the result register loads from it when the byte advances, so a result
// passes both registers before its out transaction.
// The decode state update is a shift-or of one 7-bit group.
// arst_n clears the stage valids and element state and resets value_type to varint64 at once.
// A stalled out channel holds its result; the input register then fills and in_ready drops.
// cfg_ready is always high; the user must write value_type between regions while the block is idle (not enforced).
module packed_varint_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        region_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic        malformed,
	output logic        is_last,
	output logic [15:0] element_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);
	import pvsd_pkg::*;

	logic              s1_valid_q;
	logic [7:0]        data_byte_s1;
	logic              region_end_s1;
	logic [TYPE_W-1:0] value_type_q;
	logic              can_load;
	logic              advance;
	res_req_t          req;
	res_t              res;

	// the byte in the input register moves on whenever the result register is free or its result is being taken
	assign advance   = s1_valid_q && can_load;
	assign in_ready  = !s1_valid_q || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			value_type_q <= VT_RESET;
		end else begin
			if (in_ready)
				s1_valid_q <= in_valid;
			if (cfg_valid)
				value_type_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_byte_s1  <= data_byte;
			region_end_s1 <= region_end;
		end
	end

	pvsd_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.data_byte_s1 (data_byte_s1),
		.region_end_s1(region_end_s1),
		.value_type   (value_type_q),
		.req          (req)
	);

	pvsd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.req      (req),
		.can_load (can_load),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res      (res)
	);

	assign value         = res.value;
	assign malformed     = res.malformed;
	assign is_last       = res.is_last;
	assign element_index = res.element_index;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !advance) |=> (s1_valid_q && $stable(data_byte_s1)
			&& $stable(region_end_s1)))
		else $error("stalled input byte lost");

	a_out_malformed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && malformed) |-> (is_last && value == 64'd0))
		else $error("malformed result format");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid && !out_ready) |-> !in_ready)
		else $error("input taken with both stages full");

endmodule

// File: design/pvsd_decode.sv
// Decode stage: element state, group gathering, error detection and type conversion.
module pvsd_decode (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [7:0]                     data_byte_s1,
	input  logic                           region_end_s1,
	input  logic [pvsd_pkg::TYPE_W-1:0]    value_type,
	output pvsd_pkg::res_req_t             req
);
	import pvsd_pkg::*;

	logic [VALUE_W-1:0] acc_q;
	logic [CNT_W-1:0]   gc_q;
	logic               discard_q;
	logic [INDEX_W-1:0] elem_q;

	logic               cont;
	logic [CNT_W-1:0]   gc_next;
	logic [VALUE_W-1:0] acc_new;
	logic               too_long;

	assign cont     = data_byte_s1[CONT_BIT];
	assign gc_next  = gc_q + CNT_W'(1);
	assign acc_new  = acc_q | place_group(gc_q, data_byte_s1[GROUP_W-1:0]);
	assign too_long = gc_next >= MAX_GROUPS;

	always_comb begin
		req.valid             = 1'b0;
		req.res.value         = '0;
		req.res.malformed     = 1'b0;
		req.res.is_last       = 1'b0;
		req.res.element_index = elem_q;
		if (!discard_q) begin
			if (cont) begin
				if (too_long || region_end_s1) begin
					req.valid         = 1'b1;
					req.res.malformed = 1'b1;
					req.res.is_last   = 1'b1;
				end
			end else begin
				req.valid       = 1'b1;
				req.res.value   = convert(value_type, acc_new);
				req.res.is_last = region_end_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			gc_q      <= '0;
			discard_q <= 1'b0;
			elem_q    <= '0;
		end else if (step) begin
			if (discard_q) begin
				if (region_end_s1) begin
					discard_q <= 1'b0;
					elem_q    <= '0;
				end
			end else if (cont) begin
				if (region_end_s1) begin
					acc_q  <= '0;
					gc_q   <= '0;
					elem_q <= '0;
				end else if (too_long) begin
					acc_q     <= '0;
					gc_q      <= '0;
					discard_q <= 1'b1;
				end else begin
					acc_q <= acc_new;
					gc_q  <= gc_next;
				end
			end else begin
				acc_q <= '0;
				gc_q  <= '0;
				if (region_end_s1)
					elem_q <= '0;
				else if (elem_q != INDEX_MAX)
					elem_q <= elem_q + INDEX_W'(1);
			end
		end
	end

	a_gc_range: assert property (@(posedge clk) disable iff (!arst_n)
		gc_q < MAX_GROUPS)
		else $error("group count out of range");

	a_discard_clean: assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> (acc_q == '0 && gc_q == '0))
		else $error("accumulator not cleared while discarding");

	a_malformed_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.res.malformed) |-> (req.res.is_last && req.res.value == '0))
		else $error("malformed result not zero or not last");

	a_quiet_discard: assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> !req.valid)
		else $error("result produced while discarding");

endmodule

// File: design/pvsd_out_reg.sv
// Result register: holds one result until the downstream side takes it.
module pvsd_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  pvsd_pkg::res_req_t     req,
	output logic                   can_load,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pvsd_pkg::res_t         res
);
	import pvsd_pkg::*;

	logic valid_q;
	res_t res_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= req.valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && req.valid)
			res_q <= req.res;
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |-> !load)
		else $error("pending result overwritten");

endmodule
